### hdl/hrhp_pkg.sv
// package for the http request head parser
// holds byte constants, phase, field, status and error codes and the shared structs
// no dependencies
package hrhp_pkg;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [8:0] VERSION_LEN = 9'd8;

   localparam int METHOD_MAX_DEF   = 8;
   localparam int RESOURCE_MAX_DEF = 256;
   localparam int NAME_MAX_DEF     = 64;
   localparam int VALUE_MAX_DEF    = 256;
   localparam int HEADERS_MAX_DEF  = 16;

   typedef enum logic [3:0] {
      PH_METHOD   = 4'd0,
      PH_RESOURCE = 4'd1,
      PH_VERSION  = 4'd2,
      PH_RL_CR    = 4'd3,
      PH_RL_LF    = 4'd4,
      PH_NAME     = 4'd5,
      PH_NAME_CR  = 4'd6,
      PH_SPACE    = 4'd7,
      PH_VALUE    = 4'd8,
      PH_VAL_LF   = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      FK_METHOD   = 3'd0,
      FK_RESOURCE = 3'd1,
      FK_VERSION  = 3'd2,
      FK_NAME     = 3'd3,
      FK_VALUE    = 3'd4,
      FK_DELIM    = 3'd5
   } field_kind_type;

   typedef enum logic [1:0] {
      ST_BUSY  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ERR_NONE          = 4'd0,
      ERR_METHOD_LONG   = 4'd1,
      ERR_RESOURCE_LONG = 4'd2,
      ERR_NO_CR         = 4'd3,
      ERR_NO_LF         = 4'd4,
      ERR_NAME_LONG     = 4'd5,
      ERR_NO_SPACE      = 4'd6,
      ERR_VALUE_LONG    = 4'd7,
      ERR_TOO_MANY      = 4'd8
   } error_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] field_index;
      logic [3:0] header_count;
   } state_type;

   typedef struct packed {
      logic [7:0]     byte_out;
      field_kind_type field_kind;
      logic [7:0]     position;
      logic [3:0]     header_number;
      status_type     status;
      error_type      error_code;
   } result_type;

   localparam state_type RESET_STATE = '{phase: PH_METHOD, field_index: 8'd0,
                                         header_count: 4'd0};

endpackage

### hdl/hrhp_if.sv
// valid/ready channel interfaces for the http request head parser
// request channel carries one byte, response channel carries one tagged byte
// no dependencies
interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface hrhp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic [2:0] field_kind;
   logic [7:0] position;
   logic [3:0] header_number;
   logic [1:0] status;
   logic [3:0] error_code;

   modport source (output valid, output byte_out, output field_kind, output position,
                   output header_number, output status, output error_code, input ready);
   modport sink (input valid, input byte_out, input field_kind, input position,
                 input header_number, input status, input error_code, output ready);
endinterface

### hdl/hrhp_step.sv
// one-byte step of the http request head parser: next state and tagged result
// purely combinational; depends on hrhp_pkg
module hrhp_step #(
   parameter int METHOD_MAX   = hrhp_pkg::METHOD_MAX_DEF,
   parameter int RESOURCE_MAX = hrhp_pkg::RESOURCE_MAX_DEF,
   parameter int NAME_MAX     = hrhp_pkg::NAME_MAX_DEF,
   parameter int VALUE_MAX    = hrhp_pkg::VALUE_MAX_DEF,
   parameter int HEADERS_MAX  = hrhp_pkg::HEADERS_MAX_DEF
) (
   input  hrhp_pkg::state_type  cur_state,
   input  logic [7:0]           byte_in,
   output hrhp_pkg::state_type  nxt_state,
   output hrhp_pkg::result_type result
);
   import hrhp_pkg::*;

   localparam logic [8:0] METHOD_LIM   = 9'(METHOD_MAX);
   localparam logic [8:0] RESOURCE_LIM = 9'(RESOURCE_MAX);
   localparam logic [8:0] NAME_LIM     = 9'(NAME_MAX);
   localparam logic [8:0] VALUE_LIM    = 9'(VALUE_MAX);
   localparam logic [4:0] HEADERS_LIM  = 5'(HEADERS_MAX);

   logic [8:0]     fi_inc;
   logic [4:0]     hc_inc;
   logic           store_en;
   field_kind_type store_kind;
   logic [8:0]     store_lim;
   error_type      store_err;
   logic           restart;

   assign fi_inc = {1'b0, cur_state.field_index} + 9'd1;
   assign hc_inc = {1'b0, cur_state.header_count} + 5'd1;

   always_comb begin
      nxt_state  = cur_state;
      result     = '{byte_out: 8'd0, field_kind: FK_DELIM, position: 8'd0,
                     header_number: cur_state.header_count, status: ST_BUSY,
                     error_code: ERR_NONE};
      store_en   = 1'b0;
      store_kind = FK_METHOD;
      store_lim  = METHOD_LIM;
      store_err  = ERR_METHOD_LONG;
      restart    = 1'b0;

      unique case (cur_state.phase)
         PH_METHOD: begin
            if (byte_in == CH_SP) begin
               nxt_state.phase       = PH_RESOURCE;
               nxt_state.field_index = 8'd0;
            end else begin
               store_en = 1'b1;
            end
         end
         PH_RESOURCE: begin
            if (byte_in == CH_SP) begin
               nxt_state.phase       = PH_VERSION;
               nxt_state.field_index = 8'd0;
            end else begin
               store_en   = 1'b1;
               store_kind = FK_RESOURCE;
               store_lim  = RESOURCE_LIM;
               store_err  = ERR_RESOURCE_LONG;
            end
         end
         PH_VERSION: begin
            result.byte_out   = byte_in;
            result.field_kind = FK_VERSION;
            result.position   = cur_state.field_index;
            if (fi_inc >= VERSION_LEN) begin
               nxt_state.phase       = PH_RL_CR;
               nxt_state.field_index = 8'd0;
            end else begin
               nxt_state.field_index = fi_inc[7:0];
            end
         end
         PH_RL_CR: begin
            if (byte_in == CH_CR) begin
               nxt_state.phase       = PH_RL_LF;
               nxt_state.field_index = 8'd0;
            end else begin
               result.status     = ST_ERROR;
               result.error_code = ERR_NO_CR;
               restart           = 1'b1;
            end
         end
         PH_RL_LF: begin
            if (byte_in == CH_LF) begin
               nxt_state.phase        = PH_NAME;
               nxt_state.field_index  = 8'd0;
               nxt_state.header_count = 4'd0;
               result.header_number   = 4'd0;
            end else begin
               result.status     = ST_ERROR;
               result.error_code = ERR_NO_LF;
               restart           = 1'b1;
            end
         end
         PH_NAME: begin
            if (byte_in == CH_COLON) begin
               nxt_state.phase = PH_SPACE;
            end else if (byte_in == CH_CR) begin
               nxt_state.phase = PH_NAME_CR;
            end else begin
               store_en   = 1'b1;
               store_kind = FK_NAME;
               store_lim  = NAME_LIM;
               store_err  = ERR_NAME_LONG;
            end
         end
         PH_NAME_CR: begin
            if (byte_in == CH_LF) begin
               result.status = ST_DONE;
               restart       = 1'b1;
            end else begin
               nxt_state.phase = PH_NAME;
               store_en        = 1'b1;
               store_kind      = FK_NAME;
               store_lim       = NAME_LIM;
               store_err       = ERR_NAME_LONG;
            end
         end
         PH_SPACE: begin
            if (byte_in == CH_SP) begin
               nxt_state.phase       = PH_VALUE;
               nxt_state.field_index = 8'd0;
            end else begin
               result.status     = ST_ERROR;
               result.error_code = ERR_NO_SPACE;
               restart           = 1'b1;
            end
         end
         PH_VALUE: begin
            if (byte_in == CH_CR) begin
               nxt_state.phase = PH_VAL_LF;
            end else begin
               store_en   = 1'b1;
               store_kind = FK_VALUE;
               store_lim  = VALUE_LIM;
               store_err  = ERR_VALUE_LONG;
            end
         end
         PH_VAL_LF: begin
            if (byte_in != CH_LF) begin
               result.status     = ST_ERROR;
               result.error_code = ERR_NO_LF;
               restart           = 1'b1;
            end else if (hc_inc >= HEADERS_LIM) begin
               result.status     = ST_ERROR;
               result.error_code = ERR_TOO_MANY;
               restart           = 1'b1;
            end else begin
               nxt_state.phase        = PH_NAME;
               nxt_state.field_index  = 8'd0;
               nxt_state.header_count = hc_inc[3:0];
            end
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      if (store_en) begin
         result.byte_out       = byte_in;
         result.field_kind     = store_kind;
         result.position       = cur_state.field_index;
         nxt_state.field_index = fi_inc[7:0];
         if (fi_inc >= store_lim) begin
            result.status     = ST_ERROR;
            result.error_code = store_err;
            restart           = 1'b1;
         end
      end

      if (restart) begin
         nxt_state = RESET_STATE;
      end
   end

endmodule

### hdl/http_request_head_parser.sv
// top level of the http request head parser
// parser state register, step logic and registered response; depends on hrhp_pkg,
// hrhp_if and hrhp_step
//
// usage:
//   req_chan carries the request head one byte per transaction (byte_in)
//   rsp_chan returns exactly one tagged transaction per request byte: the byte,
//   its field kind, position within the field, header number, status and
//   error code
//   the response is registered and valid the cycle after the byte is accepted
//   throughput: one byte per cycle while the receiver drains responses; the
//   single-byte state update and the response register set that figure
//   req_chan.ready is high while the response register is empty or being
//   drained, so a stalled receiver holds one response and back-pressures the
//   sender only in that case
//   a response with status complete or error returns the parser to the start
//   of a new request
//   reset clears the parser to the method field and empties the response
//   register
module http_request_head_parser #(
   parameter int METHOD_MAX   = hrhp_pkg::METHOD_MAX_DEF,
   parameter int RESOURCE_MAX = hrhp_pkg::RESOURCE_MAX_DEF,
   parameter int NAME_MAX     = hrhp_pkg::NAME_MAX_DEF,
   parameter int VALUE_MAX    = hrhp_pkg::VALUE_MAX_DEF,
   parameter int HEADERS_MAX  = hrhp_pkg::HEADERS_MAX_DEF
) (
   input logic         clock,
   input logic         reset,
   hrhp_req_if.sink    req_chan,
   hrhp_rsp_if.source  rsp_chan
);
   import hrhp_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   state_type  step_state;
   result_type step_res;
   result_type rsp_data_ff;
   result_type rsp_data_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_fire;

   hrhp_step #(
      .METHOD_MAX   (METHOD_MAX),
      .RESOURCE_MAX (RESOURCE_MAX),
      .NAME_MAX     (NAME_MAX),
      .VALUE_MAX    (VALUE_MAX),
      .HEADERS_MAX  (HEADERS_MAX)
   ) u_step (
      .cur_state (state_ff),
      .byte_in   (req_chan.byte_in),
      .nxt_state (step_state),
      .result    (step_res)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in     = state_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (req_fire) begin
         state_in     = step_state;
         rsp_data_in  = step_res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RESET_STATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.byte_out      = rsp_data_ff.byte_out;
   assign rsp_chan.field_kind    = rsp_data_ff.field_kind;
   assign rsp_chan.position      = rsp_data_ff.position;
   assign rsp_chan.header_number = rsp_data_ff.header_number;
   assign rsp_chan.status        = rsp_data_ff.status;
   assign rsp_chan.error_code    = rsp_data_ff.error_code;

`ifndef ASSERT_OFF
   a_restart_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step_res.status != ST_BUSY) |=> (state_ff == RESET_STATE))
      else $error("parser did not restart after a finished head");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted byte produced no response");

   a_version_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_VERSION) |-> ({1'b0, state_ff.field_index} < VERSION_LEN))
      else $error("version index out of range");

   a_delim_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.field_kind == FK_DELIM)
         |-> (rsp_data_ff.byte_out == 8'd0 && rsp_data_ff.position == 8'd0))
      else $error("delimiter response carries data");

   a_error_code_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.status == ST_ERROR)
                        == (rsp_data_ff.error_code != ERR_NONE)))
      else $error("error code disagrees with status");
`endif

endmodule

### tb/sv/tb_http_request_head_parser.sv
// self-checking testbench for the http request head parser
// drives request bytes, predicts every tagged response byte and checks it field by field;
// depends on hrhp_pkg, hrhp_if and http_request_head_parser
module tb_http_request_head_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import hrhp_pkg::*;

   localparam int METHOD_MAX   = METHOD_MAX_DEF;
   localparam int RESOURCE_MAX = RESOURCE_MAX_DEF;
   localparam int NAME_MAX     = NAME_MAX_DEF;
   localparam int VALUE_MAX    = VALUE_MAX_DEF;
   localparam int HEADERS_MAX  = HEADERS_MAX_DEF;

   localparam int BYTE_BUDGET  = 1050;
   localparam int CALM_FROM    = 900;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 120;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [7:0] data;
      logic       known;
      result_type tag;
   } stim_row_type;

   localparam stim_row_type DIRECTED [24] = '{
      '{data: 8'h00, known: 1'b1, tag: '{8'h00, FK_METHOD, 8'd0, 4'd0, ST_BUSY, ERR_NONE}},
      '{data: 8'hFF, known: 1'b0, tag: '0},
      '{data: 8'h41, known: 1'b0, tag: '0},
      '{data: 8'h0D, known: 1'b0, tag: '0},
      '{data: 8'h0A, known: 1'b0, tag: '0},
      '{data: 8'h3A, known: 1'b0, tag: '0},
      '{data: 8'h7F, known: 1'b0, tag: '0},
      '{data: 8'h80, known: 1'b1,
        tag: '{8'h80, FK_METHOD, 8'd7, 4'd0, ST_ERROR, ERR_METHOD_LONG}},
      '{data: 8'h20, known: 1'b1, tag: '{8'h00, FK_DELIM, 8'd0, 4'd0, ST_BUSY, ERR_NONE}},
      '{data: 8'h20, known: 1'b0, tag: '0},
      '{data: 8'h20, known: 1'b0, tag: '0},
      '{data: 8'h0D, known: 1'b0, tag: '0},
      '{data: 8'h0A, known: 1'b0, tag: '0},
      '{data: 8'h3A, known: 1'b0, tag: '0},
      '{data: 8'hFF, known: 1'b0, tag: '0},
      '{data: 8'h00, known: 1'b0, tag: '0},
      '{data: 8'h31, known: 1'b0, tag: '0},
      '{data: 8'h2E, known: 1'b0, tag: '0},
      '{data: 8'h0D, known: 1'b0, tag: '0},
      '{data: 8'h0A, known: 1'b0, tag: '0},
      '{data: 8'h0D, known: 1'b0, tag: '0},
      '{data: 8'h78, known: 1'b0, tag: '0},
      '{data: 8'h3A, known: 1'b0, tag: '0},
      '{data: 8'h79, known: 1'b1,
        tag: '{8'h00, FK_DELIM, 8'd0, 4'd0, ST_ERROR, ERR_NO_SPACE}}
   };

   logic clock;
   logic reset;

   hrhp_req_if req_chan ();
   hrhp_rsp_if rsp_chan ();

   http_request_head_parser u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // parser state mirror
   phase_type  parse_phase;
   logic [8:0] parse_index;
   logic [4:0] parse_headers;

   result_type  pending_tags [$];
   result_type  want;
   int unsigned bytes_sent;
   int unsigned requests_sent;
   int unsigned tags_checked;
   int unsigned heads_done;
   int unsigned heads_failed;
   int unsigned mismatches;
   int unsigned cycles;
   int unsigned source_calm;
   int unsigned sink_calm;
   bit          tail_calm;
   bit          hold_off;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void store_byte(inout result_type r, input logic [7:0] b,
                                      input field_kind_type kind, input int lim,
                                      input error_type err);
      r.byte_out   = b;
      r.field_kind = kind;
      r.position   = parse_index[7:0];
      parse_index  = parse_index + 9'd1;
      if (parse_index >= lim) begin
         r.status     = ST_ERROR;
         r.error_code = err;
      end
   endfunction

   function automatic result_type parse_byte(logic [7:0] b);
      result_type r;
      r = '{8'h00, FK_DELIM, 8'd0, parse_headers[3:0], ST_BUSY, ERR_NONE};
      case (parse_phase)
         PH_METHOD: begin
            if (b == CH_SP) begin
               parse_phase = PH_RESOURCE;
               parse_index = '0;
            end else begin
               store_byte(r, b, FK_METHOD, METHOD_MAX, ERR_METHOD_LONG);
            end
         end
         PH_RESOURCE: begin
            if (b == CH_SP) begin
               parse_phase = PH_VERSION;
               parse_index = '0;
            end else begin
               store_byte(r, b, FK_RESOURCE, RESOURCE_MAX, ERR_RESOURCE_LONG);
            end
         end
         PH_VERSION: begin
            r.byte_out   = b;
            r.field_kind = FK_VERSION;
            r.position   = parse_index[7:0];
            parse_index  = parse_index + 9'd1;
            if (parse_index >= VERSION_LEN) begin
               parse_phase = PH_RL_CR;
               parse_index = '0;
            end
         end
         PH_RL_CR: begin
            if (b == CH_CR) parse_phase = PH_RL_LF;
            else begin
               r.status     = ST_ERROR;
               r.error_code = ERR_NO_CR;
            end
         end
         PH_RL_LF: begin
            if (b == CH_LF) begin
               parse_phase   = PH_NAME;
               parse_index   = '0;
               parse_headers = '0;
            end else begin
               r.status     = ST_ERROR;
               r.error_code = ERR_NO_LF;
            end
         end
         PH_NAME: begin
            if (b == CH_COLON) parse_phase = PH_SPACE;
            else if (b == CH_CR) parse_phase = PH_NAME_CR;
            else store_byte(r, b, FK_NAME, NAME_MAX, ERR_NAME_LONG);
         end
         PH_NAME_CR: begin
            if (b == CH_LF) r.status = ST_DONE;
            else begin
               parse_phase = PH_NAME;
               store_byte(r, b, FK_NAME, NAME_MAX, ERR_NAME_LONG);
            end
         end
         PH_SPACE: begin
            if (b == CH_SP) begin
               parse_phase = PH_VALUE;
               parse_index = '0;
            end else begin
               r.status     = ST_ERROR;
               r.error_code = ERR_NO_SPACE;
            end
         end
         PH_VALUE: begin
            if (b == CH_CR) parse_phase = PH_VAL_LF;
            else store_byte(r, b, FK_VALUE, VALUE_MAX, ERR_VALUE_LONG);
         end
         PH_VAL_LF: begin
            if (b == CH_LF) begin
               parse_headers = parse_headers + 5'd1;
               parse_phase   = PH_NAME;
               parse_index   = '0;
               if (parse_headers >= HEADERS_MAX) begin
                  r.status     = ST_ERROR;
                  r.error_code = ERR_TOO_MANY;
               end
            end else begin
               r.status     = ST_ERROR;
               r.error_code = ERR_NO_LF;
            end
         end
         default: parse_phase = PH_METHOD;
      endcase
      if (r.status != ST_BUSY) begin
         parse_phase   = PH_METHOD;
         parse_index   = '0;
         parse_headers = '0;
      end
      return r;
   endfunction

   function automatic bit idle_now(inout int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 1'b0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(20, 60);
         return 1'b0;
      end
      return $urandom_range(0, 3) == 0;
   endfunction

   function automatic logic [7:0] any_but(logic [7:0] x, logic [7:0] y);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == x || b == y);
      return b;
   endfunction

   function automatic int unsigned pick_len(int unsigned lim, int unsigned typical,
                                            int unsigned odds);
      int unsigned r;
      r = $urandom_range(0, odds - 1);
      if (r == 0) return lim;
      if (r == 1) return lim - 1;
      if (r == 2) return 0;
      return $urandom_range(1, typical);
   endfunction

   function automatic bit broken();
      return $urandom_range(0, 29) == 0;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit known = 1'b0,
                            input result_type tag = '0);
      result_type predicted;
      if (!tail_calm && idle_now(source_calm)) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.byte_in <= b;
      do @(posedge clock); while (!req_chan.ready);
      predicted = parse_byte(b);
      pending_tags.push_back(known ? tag : predicted);
      bytes_sent++;
      if (bytes_sent >= CALM_FROM) tail_calm <= 1'b1;
   endtask

   task automatic send_request();
      int unsigned n;
      int unsigned nh;
      requests_sent++;
      n = pick_len(METHOD_MAX, 6, 12);
      repeat (n) send_byte(any_but(CH_SP, CH_SP));
      if (n >= METHOD_MAX) return;
      send_byte(CH_SP);
      n = pick_len(RESOURCE_MAX, 24, 60);
      repeat (n) send_byte(any_but(CH_SP, CH_SP));
      if (n >= RESOURCE_MAX) return;
      send_byte(CH_SP);
      repeat (8) send_byte(8'($urandom_range(0, 255)));
      if (broken()) begin
         send_byte(any_but(CH_CR, CH_CR));
         return;
      end
      send_byte(CH_CR);
      if (broken()) begin
         send_byte(any_but(CH_LF, CH_LF));
         return;
      end
      send_byte(CH_LF);
      case ($urandom_range(0, 19))
         0: nh = HEADERS_MAX;
         1: nh = HEADERS_MAX - 1;
         default: nh = $urandom_range(0, 4);
      endcase
      // stop adding headers once the byte budget is spent
      for (int h = 0; h < nh && bytes_sent < BYTE_BUDGET; h++) begin
         n = pick_len(NAME_MAX, 12, 25);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               send_byte(CH_CR);
               send_byte(any_but(CH_LF, CH_LF));
            end else begin
               send_byte(any_but(CH_COLON, CH_CR));
            end
         end
         if (n >= NAME_MAX) return;
         send_byte(CH_COLON);
         if (broken()) begin
            send_byte(any_but(CH_SP, CH_SP));
            return;
         end
         send_byte(CH_SP);
         n = pick_len(VALUE_MAX, 24, 60);
         repeat (n) send_byte(any_but(CH_CR, CH_CR));
         if (n >= VALUE_MAX) return;
         send_byte(CH_CR);
         if (broken()) begin
            send_byte(any_but(CH_LF, CH_LF));
            return;
         end
         send_byte(CH_LF);
         if (h + 1 >= HEADERS_MAX) return;
      end
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_tags.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction, expected none, actual byte %0d kind %0d",
                     $time, rsp_chan.byte_out, rsp_chan.field_kind);
         end else begin
            want = pending_tags.pop_front();
            check_field("byte_out", want.byte_out, rsp_chan.byte_out);
            check_field("field_kind", want.field_kind, rsp_chan.field_kind);
            check_field("position", want.position, rsp_chan.position);
            check_field("header_number", want.header_number, rsp_chan.header_number);
            check_field("status", want.status, rsp_chan.status);
            check_field("error_code", want.error_code, rsp_chan.error_code);
         end
         tags_checked++;
         if (rsp_chan.status == ST_DONE) heads_done++;
         else if (rsp_chan.status == ST_ERROR) heads_failed++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver side
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            @(posedge clock);
         end else if (!tail_calm && idle_now(sink_calm)) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // long receiver stall so the parser back-pressures the sender
   initial begin
      hold_off <= 1'b0;
      wait (tags_checked >= HOLD_AT);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      parse_phase   = PH_METHOD;
      parse_index   = '0;
      parse_headers = '0;
      bytes_sent    = 0;
      requests_sent = 0;
      tags_checked  = 0;
      heads_done    = 0;
      heads_failed  = 0;
      mismatches    = 0;
      cycles        = 0;
      source_calm   = 0;
      sink_calm     = 0;
      tail_calm        <= 1'b0;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.byte_in <= 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_byte(DIRECTED[i].data, DIRECTED[i].known, DIRECTED[i].tag);

      while (bytes_sent < BYTE_BUDGET) begin
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)));
         else send_request();
      end
      req_chan.valid <= 1'b0;

      while (pending_tags.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d request bytes sent in %0d generated requests, %0d responses checked",
               bytes_sent, requests_sent, tags_checked);
      $display("%0d heads completed, %0d rejected with an error code, %0d mismatches",
               heads_done, heads_failed, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/hrhp_pkg.sv
hdl/hrhp_if.sv
hdl/hrhp_step.sv
hdl/http_request_head_parser.sv
tb/sv/tb_http_request_head_parser.sv
